/* hw/rtl/ucwf_pkg.sv */
// Shared types, codes and byte classification for the UTF-8 whitelist filter.
package ucwf_pkg;

  localparam int QueueDepthDefault = 4;

  localparam logic [7:0] SpaceByte = 8'h20;

  // Command kinds passed from the parser to the expander.
  localparam logic [1:0] KIND_SINGLE = 2'd0;  // one byte: itself or two spaces
  localparam logic [1:0] KIND_PAIR   = 2'd1;  // two bytes: both, or one space
  localparam logic [1:0] KIND_WIDE   = 2'd2;  // 3/4-byte sequence: four spaces

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       last;
  } cmd_t;

  function automatic logic [2:0] class_length(input logic [7:0] b);
    logic [2:0] len;
    if ((b & 8'hF8) == 8'hF0) len = 3'd4;
    else if ((b & 8'hF0) == 8'hE0) len = 3'd3;
    else if ((b & 8'hE0) == 8'hC0) len = 3'd2;
    else len = 3'd1;
    return len;
  endfunction

  function automatic logic single_ok(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h30 && b <= 8'h39) ||
           (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic logic pair_ok(input logic [7:0] b0, input logic [7:0] b1);
    logic [15:0] code;
    code = {b0, b1};
    return (code >= 16'hC380) && (code <= 16'hC897);
  endfunction

  // Number of output bytes a command expands into (1..4).
  function automatic logic [2:0] expand_count(input cmd_t c);
    logic [2:0] n;
    case (c.kind)
      KIND_SINGLE: n = single_ok(c.b0) ? 3'd1 : 3'd2;
      KIND_PAIR:   n = pair_ok(c.b0, c.b1) ? 3'd2 : 3'd1;
      KIND_WIDE:   n = 3'd4;
      default:     n = 3'd1;
    endcase
    return n;
  endfunction

  // Output byte number idx of a command.
  function automatic logic [7:0] expand_byte(input cmd_t c, input logic [1:0] idx);
    logic [7:0] b;
    case (c.kind)
      KIND_SINGLE: b = single_ok(c.b0) ? c.b0 : SpaceByte;
      KIND_PAIR: begin
        if (pair_ok(c.b0, c.b1)) b = (idx == 2'd0) ? c.b0 : c.b1;
        else b = SpaceByte;
      end
      default:     b = SpaceByte;
    endcase
    return b;
  endfunction

endpackage

/* hw/rtl/ucwf_front.sv */
// Front end: gathers UTF-8 sequences and turns them into expand commands.
module ucwf_front
  import ucwf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       q_full,
  output logic       push,
  output cmd_t       push_cmd
);

  logic [7:0] held [3];
  logic [1:0] held_count;
  logic [2:0] seq_len;

  // commands left over from a cut-short sequence
  cmd_t       pend [2];
  logic [1:0] pend_cnt;

  logic       accept;
  logic       acc_push;
  cmd_t       acc_cmd;
  logic [2:0] lead_len;
  logic [2:0] fill;
  logic       cut;
  cmd_t       cut_cmd0;
  cmd_t       cut_cmd1;
  logic [1:0] cut_cnt;

  assign in_stall = (pend_cnt != 2'd0) || q_full;
  assign accept   = in_valid && !in_stall;
  assign lead_len = class_length(in_byte);
  assign fill     = {1'b0, held_count} + 3'd1;

  always_comb begin
    acc_push = 1'b0;
    acc_cmd  = '{kind: KIND_SINGLE, b0: in_byte, b1: in_byte, last: in_last};
    cut      = 1'b0;
    cut_cmd0 = '{kind: KIND_SINGLE, b0: in_byte, b1: in_byte, last: 1'b1};
    cut_cmd1 = '{kind: KIND_SINGLE, b0: in_byte, b1: in_byte, last: 1'b1};
    cut_cnt  = 2'd0;
    if (held_count == 2'd0) begin
      // a lone lead byte at the end of text falls back to single
      acc_push = (lead_len == 3'd1) || in_last;
    end else if (fill >= seq_len) begin
      acc_push = 1'b1;
      acc_cmd.kind = (seq_len == 3'd2) ? KIND_PAIR : KIND_WIDE;
      acc_cmd.b0   = held[0];
      acc_cmd.b1   = in_byte;
    end else if (in_last) begin
      // cut short: lead goes out as a single, the rest is reparsed
      acc_push     = 1'b1;
      acc_cmd.b0   = held[0];
      acc_cmd.last = 1'b0;
      cut          = 1'b1;
      if (held_count == 2'd1) begin
        cut_cnt = 2'd1;
      end else if (class_length(held[1]) == 3'd2) begin
        cut_cnt       = 2'd1;
        cut_cmd0.kind = KIND_PAIR;
        cut_cmd0.b0   = held[1];
      end else begin
        cut_cnt       = 2'd2;
        cut_cmd0.b0   = held[1];
        cut_cmd0.last = 1'b0;
      end
    end
  end

  always_comb begin
    if (pend_cnt != 2'd0) begin
      push     = !q_full;
      push_cmd = pend[0];
    end else begin
      push     = accept && acc_push;
      push_cmd = acc_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
      seq_len    <= 3'd1;
      pend_cnt   <= 2'd0;
    end else begin
      if (pend_cnt != 2'd0 && !q_full) begin
        pend[0]  <= pend[1];
        pend_cnt <= pend_cnt - 2'd1;
      end
      if (accept) begin
        if (acc_push) begin
          held_count <= 2'd0;
          seq_len    <= 3'd1;
        end else begin
          held[held_count] <= in_byte;
          held_count       <= held_count + 2'd1;
          if (held_count == 2'd0) seq_len <= lead_len;
        end
        if (cut) begin
          pend[0]  <= cut_cmd0;
          pend[1]  <= cut_cmd1;
          pend_cnt <= cut_cnt;
        end
      end
    end
  end

endmodule

/* hw/rtl/ucwf_queue.sv */
// Small register FIFO of expand commands between front and back end.
module ucwf_queue
  import ucwf_pkg::*;
#(
  parameter int DEPTH = QueueDepthDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic full,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head  = entries[rd_ptr];
  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

/* hw/rtl/ucwf_back.sv */
// Back end: expands commands into output bytes through an output register.
module ucwf_back
  import ucwf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  cmd_t       head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last
);

  cmd_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic [2:0] n_bytes;
  logic       out_load;
  logic       take;
  logic       done;

  assign n_bytes  = expand_count(cur);
  assign out_load = !out_valid || !out_stall;
  assign take     = cur_valid && out_load;
  assign done     = take && ({1'b0, idx} == n_bytes - 3'd1);
  assign pop      = !q_empty && (!cur_valid || done);

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte <= expand_byte(cur, idx);
      out_last <= cur.last && ({1'b0, idx} == n_bytes - 3'd1);
    end
    if (pop) cur <= head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (out_load) out_valid <= cur_valid;
      if (pop) begin
        cur_valid <= 1'b1;
        idx       <= 2'd0;
      end else if (done) begin
        cur_valid <= 1'b0;
      end else if (take) begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule

/* hw/rtl/utf8_character_whitelist_filter.sv */
// Top level of the UTF-8 character whitelist filter.
//
// Input channel (in_valid / in_stall / in_byte / in_last) takes one raw
// UTF-8 byte per request; in_last marks the final byte of a text.
// Output channel (out_valid / out_stall / out_byte / out_last) gives the
// filtered bytes; out_last rides on the final result byte of a text.
// A request is taken at a clock edge with valid high and stall low.
//
// A request's result bytes pass parser -> queue -> expander command
// register -> output register. The expander writes one output byte per
// cycle while commands are queued and out_stall is low; a request yields
// 0 to 4 bytes (up to 6 at a cut-short end of text). The parser takes one
// byte per cycle while in_stall is low; it holds in_stall while it queues
// the leftovers of a sequence cut short by in_last.
// When out_stall is high with out_valid set, the output register holds; the command queue
// fills and then in_stall rises, so nothing is dropped.
// Reset (rst, synchronous) empties the queue and the output register and
// forgets any partly gathered sequence.
module utf8_character_whitelist_filter
  import ucwf_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic q_push;
  cmd_t q_push_cmd;
  logic q_pop;
  cmd_t q_head;
  logic q_full;
  logic q_empty;

  // Parser: gathers lead and continuation bytes, classifies the sequence.
  ucwf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .q_full   (q_full),
    .push     (q_push),
    .push_cmd (q_push_cmd)
  );

  // Decouples the parser from output back-pressure.
  ucwf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Expander: one output byte per cycle from the queued commands while out_stall is low.
  ucwf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .head      (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  // parser never writes a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("command pushed into full queue");

  // expander never reads an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && q_empty))
    else $error("command popped from empty queue");

  // nothing comes out right after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule
